[sv/idc_pkg.sv]
package idc_pkg;

   localparam int DEFAULT_NUM_IRQS = 192;

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_LINE  = 2'd2;

   localparam logic [15:0] ADDR_DIST_CTRL = 16'h0000;
   localparam logic [15:0] ADDR_TYPE      = 16'h0001;
   localparam logic [15:0] ADDR_BITS_LO   = 16'h0040;
   localparam logic [15:0] ADDR_PRIO_LO   = 16'h0100;
   localparam logic [15:0] ADDR_TGT_LO    = 16'h0200;
   localparam logic [15:0] ADDR_TRIG_LO   = 16'h0300;
   localparam logic [15:0] ADDR_TRIG_HI   = 16'h0340;
   localparam logic [15:0] ADDR_CPU_CTRL  = 16'h4000;
   localparam logic [15:0] ADDR_PMASK     = 16'h4001;
   localparam logic [15:0] ADDR_BPOINT    = 16'h4002;
   localparam logic [15:0] ADDR_ACK       = 16'h4003;
   localparam logic [15:0] ADDR_EOI       = 16'h4004;
   localparam logic [15:0] ADDR_RUN_PRIO  = 16'h4005;
   localparam logic [15:0] ADDR_HIGH_PEND = 16'h4006;

   localparam logic [2:0] GRP_SET_EN   = 3'd0;
   localparam logic [2:0] GRP_CLR_EN   = 3'd1;
   localparam logic [2:0] GRP_SET_PEND = 3'd2;
   localparam logic [2:0] GRP_CLR_PEND = 3'd3;
   localparam logic [2:0] GRP_SET_ACT  = 3'd4;
   localparam logic [2:0] GRP_CLR_ACT  = 3'd5;

   localparam logic [9:0] SPURIOUS_ID = 10'h3ff;
   localparam logic [7:0] IDLE_PRIO   = 8'hff;
   localparam logic [8:0] NO_PRIO     = 9'h100;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] word_addr;
      logic [31:0] write_data;
      logic [7:0]  source_id;
      logic        source_level;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_request;
   } rsp_type;

   typedef struct packed {
      logic clr_en;
      logic take;
      logic scan_init;
      logic scan_en;
      logic ack_apply;
      logic issue;
      logic capture;
      logic respond;
   } idc_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic scan_last;
      logic start_ack;
   } idc_status_type;

endpackage

[sv/interrupt_distributor_cpu_interface.sv]
// channel   ports                          handshake
// request   start, busy, req_data          taken when start && !busy
// response  rsp_valid, rsp_data            one-cycle strobe, always taken
//
// Every request runs a scan over all interrupts, one per cycle through the
// priority and target RAM read port; an acknowledge read scans twice.
// After reset a clearing pass zeroes both RAMs; busy stays high meanwhile.
// The response strobe cannot be stalled.
module interrupt_distributor_cpu_interface
   import idc_pkg::*;
#(
   parameter int NUM_IRQS = DEFAULT_NUM_IRQS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   idc_cmd_type    cmd;
   idc_status_type status;

   idc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   idc_datapath #(.NUM_IRQS(NUM_IRQS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/idc_ram.sv]
module idc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[sv/idc_ctrl.sv]
module idc_ctrl
   import idc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  idc_status_type status,
   output logic           busy,
   output idc_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_ACK_SCAN, S_ACK_APPLY, S_ISSUE, S_DATA, S_SCAN, S_DONE
   } state_type;

   state_type state_ff;
   logic      init_ff;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.clr_en    = (state_ff == S_CLEAR);
      cmd.take      = start && (state_ff == S_IDLE);
      cmd.scan_init = init_ff;
      cmd.scan_en   = (state_ff == S_ACK_SCAN) || (state_ff == S_SCAN);
      cmd.ack_apply = (state_ff == S_ACK_APPLY);
      cmd.issue     = (state_ff == S_ISSUE);
      cmd.capture   = (state_ff == S_DATA);
      cmd.respond   = (state_ff == S_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         init_ff  <= 1'b0;
      end else begin
         init_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               if (status.clr_last) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  if (status.start_ack) begin
                     state_ff <= S_ACK_SCAN;
                     init_ff  <= 1'b1;
                  end else begin
                     state_ff <= S_ISSUE;
                  end
               end
            end
            S_ACK_SCAN: begin
               if (status.scan_last) state_ff <= S_ACK_APPLY;
            end
            S_ACK_APPLY: state_ff <= S_ISSUE;
            S_ISSUE:     state_ff <= S_DATA;
            S_DATA: begin
               state_ff <= S_SCAN;
               init_ff  <= 1'b1;
            end
            S_SCAN: begin
               if (status.scan_last) state_ff <= S_DONE;
            end
            S_DONE:      state_ff <= S_IDLE;
            default:     state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_ACK_SCAN || state_ff == S_ISSUE))
      else $error("accepted request did not start work");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (state_ff == S_IDLE))
      else $error("response state not left");
`endif

endmodule

[sv/idc_datapath.sv]
module idc_datapath
   import idc_pkg::*;
#(
   parameter int NUM_IRQS = DEFAULT_NUM_IRQS
) (
   input  logic           clock,
   input  logic           reset,
   input  idc_cmd_type    cmd,
   input  req_type        req_data,
   output idc_status_type status,
   output logic           rsp_valid,
   output rsp_type        rsp_data
);

   localparam int NW   = (NUM_IRQS + 31) / 32;
   localparam int PADN = NW * 32;
   localparam int PIW  = $clog2(PADN);
   localparam int NPW  = (NUM_IRQS + 3) / 4;
   localparam int AW   = $clog2(NPW);
   localparam int IW   = $clog2(NUM_IRQS);
   localparam int NT   = 2 * NW;
   localparam logic [PADN-1:0] VALID = {PADN{1'b1}} >> (PADN - NUM_IRQS);
   localparam logic [31:0] TYPE_VAL = 32'((NW - 1) & 31);

   req_type          req_ff;
   logic [PADN-1:0]  en_ff, pend_ff, act_ff, line_ff, tlo_ff, thi_ff;
   logic [PADN-1:0]  en_in, pend_in, act_in, line_in, tlo_in, thi_in;
   logic [1:0]       dist_ff;
   logic [3:0]       cpu_ff;
   logic [7:0]       pmask_ff;
   logic [2:0]       bp_ff;
   logic [AW-1:0]    clr_ff;
   logic [IW-1:0]    scnt_ff, sid_ff;
   logic             siss_ff, svld_ff;
   logic [8:0]       best_pri_ff;
   logic [9:0]       best_id_ff, ack_id_ff;
   logic [7:0]       run_pri_ff;
   logic [31:0]      rd_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [15:0]      a;
   logic [31:0]      d;
   logic             is_read, is_write;
   logic             in_bits, in_prio, in_tgt, in_trig;
   logic [2:0]       grp;
   logic [4:0]       w;
   logic             w_ok;
   logic [7:0]       pw;
   logic             pw_ok;
   logic [5:0]       t;
   logic             t_ok;
   logic [31:0]      bus_rd;
   logic [9:0]       best_gated;
   logic             issuing;
   logic [31:0]      prio_rdata, tgt_rdata;
   logic [7:0]       s_pri, s_tgt;
   logic             s_qual;
   logic             ram_wr_prio, ram_wr_tgt;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [31:0]      ram_wr_data;

   assign a        = req_ff.word_addr;
   assign d        = req_ff.write_data;
   assign is_read  = (req_ff.action == ACT_READ);
   assign is_write = (req_ff.action == ACT_WRITE);
   assign in_bits  = (a >= ADDR_BITS_LO) && (a < ADDR_PRIO_LO);
   assign in_prio  = (a >= ADDR_PRIO_LO) && (a < ADDR_TGT_LO);
   assign in_tgt   = (a >= ADDR_TGT_LO) && (a < ADDR_TRIG_LO);
   assign in_trig  = (a >= ADDR_TRIG_LO) && (a < ADDR_TRIG_HI);
   assign grp      = 3'(a[7:5] - 3'd2);
   assign w        = a[4:0];
   assign w_ok     = int'(w) < NW;
   assign pw       = a[7:0];
   assign pw_ok    = int'(pw) < NPW;
   assign t        = a[5:0];
   assign t_ok     = int'(t) < NT;

   assign best_gated = (dist_ff[0] && cpu_ff[0]) ? best_id_ff : SPURIOUS_ID;
   assign issuing    = cmd.scan_en && !cmd.scan_init && siss_ff;

   assign status.clr_last  = (clr_ff == AW'(NPW - 1));
   assign status.scan_last = svld_ff && (sid_ff == IW'(NUM_IRQS - 1));
   assign status.start_ack = (req_data.action == ACT_READ) &&
                             (req_data.word_addr == ADDR_ACK);

   // word-organised byte stores: four interrupts per word
   assign ram_wr_prio = cmd.clr_en || (cmd.issue && is_write && in_prio && pw_ok);
   assign ram_wr_tgt  = cmd.clr_en || (cmd.issue && is_write && in_tgt && pw_ok);
   assign ram_wr_addr = cmd.clr_en ? clr_ff : AW'(pw);
   assign ram_wr_data = cmd.clr_en ? 32'd0 : d;
   assign ram_rd_addr = cmd.scan_en ? AW'(scnt_ff >> 2) : AW'(pw);

   idc_ram #(.WIDTH(32), .DEPTH(NPW)) u_prio_ram (
      .clock   (clock),
      .wr_en   (ram_wr_prio),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (prio_rdata)
   );

   idc_ram #(.WIDTH(32), .DEPTH(NPW)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (ram_wr_tgt),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (tgt_rdata)
   );

   assign s_pri  = prio_rdata[8*int'(sid_ff[1:0]) +: 8];
   assign s_tgt  = tgt_rdata[8*int'(sid_ff[1:0]) +: 8];
   assign s_qual = en_ff[PIW'(sid_ff)] && pend_ff[PIW'(sid_ff)] &&
                   !act_ff[PIW'(sid_ff)] && (s_pri < pmask_ff) &&
                   ((int'(sid_ff) < 32) || s_tgt[0]);

   always_comb begin
      logic [31:0] m;
      logic [9:0]  n;
      logic [PIW-1:0] bg;
      en_in   = en_ff;
      pend_in = pend_ff;
      act_in  = act_ff;
      line_in = line_ff;
      tlo_in  = tlo_ff;
      thi_in  = thi_ff;
      m  = '0;
      n  = '0;
      bg = PIW'(best_gated);
      if (cmd.ack_apply && (best_gated != SPURIOUS_ID)) begin
         act_in[bg] = 1'b1;
         if (thi_ff[bg] || !line_ff[bg]) pend_in[bg] = 1'b0;
      end
      if (cmd.issue && is_write) begin
         if (in_bits && w_ok) begin
            m = d & VALID[32*int'(w) +: 32];
            unique case (grp)
               GRP_SET_EN:   en_in[32*int'(w) +: 32] = en_ff[32*int'(w) +: 32] | m;
               GRP_CLR_EN:   en_in[32*int'(w) +: 32] = en_ff[32*int'(w) +: 32] & ~m;
               GRP_SET_PEND: pend_in[32*int'(w) +: 32] = pend_ff[32*int'(w) +: 32] | m;
               // level lines held high stay pending
               GRP_CLR_PEND: pend_in[32*int'(w) +: 32] =
                  (pend_ff[32*int'(w) +: 32] & ~m) |
                  (m & ~thi_ff[32*int'(w) +: 32] & line_ff[32*int'(w) +: 32]);
               GRP_SET_ACT:  act_in[32*int'(w) +: 32] = act_ff[32*int'(w) +: 32] | m;
               GRP_CLR_ACT:  act_in[32*int'(w) +: 32] = act_ff[32*int'(w) +: 32] & ~m;
               default: ;
            endcase
         end
         if (in_trig && t_ok) begin
            for (int k = 0; k < 16; k++) begin
               if (VALID[16*int'(t) + k]) begin
                  tlo_in[16*int'(t) + k] = d[2*k];
                  thi_in[16*int'(t) + k] = d[2*k+1];
               end
            end
         end
         if (a == ADDR_EOI) begin
            n = d[9:0];
            if (int'(n) < NUM_IRQS) act_in[PIW'(n)] = 1'b0;
         end
      end
      if (cmd.issue && (req_ff.action == ACT_LINE) &&
          (int'(req_ff.source_id) < NUM_IRQS)) begin
         n = 10'(req_ff.source_id);
         line_in[PIW'(n)] = req_ff.source_level;
         if (thi_ff[PIW'(n)]) begin
            if (req_ff.source_level && !line_ff[PIW'(n)]) pend_in[PIW'(n)] = 1'b1;
         end else begin
            pend_in[PIW'(n)] = req_ff.source_level;
         end
      end
   end

   always_comb begin
      bus_rd = '0;
      if (a == ADDR_DIST_CTRL) begin
         bus_rd = 32'(dist_ff);
      end else if (a == ADDR_TYPE) begin
         bus_rd = TYPE_VAL;
      end else if (in_bits) begin
         if (w_ok) begin
            if (grp < GRP_SET_PEND)      bus_rd = en_ff[32*int'(w) +: 32];
            else if (grp < GRP_SET_ACT)  bus_rd = pend_ff[32*int'(w) +: 32];
            else                         bus_rd = act_ff[32*int'(w) +: 32];
         end
      end else if (in_prio || in_tgt) begin
         if (pw_ok) begin
            for (int k = 0; k < 4; k++) begin
               if (4*int'(pw) + k < NUM_IRQS) begin
                  bus_rd[8*k +: 8] = in_prio ? prio_rdata[8*k +: 8] : tgt_rdata[8*k +: 8];
               end
            end
         end
      end else if (in_trig) begin
         if (t_ok) begin
            for (int k = 0; k < 16; k++) begin
               bus_rd[2*k]   = tlo_ff[16*int'(t) + k];
               bus_rd[2*k+1] = thi_ff[16*int'(t) + k];
            end
         end
      end else if (a == ADDR_CPU_CTRL) begin
         bus_rd = 32'(cpu_ff);
      end else if (a == ADDR_PMASK) begin
         bus_rd = 32'(pmask_ff);
      end else if (a == ADDR_BPOINT) begin
         bus_rd = 32'(bp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff        <= '0;
         pend_ff      <= '0;
         act_ff       <= '0;
         line_ff      <= '0;
         tlo_ff       <= '0;
         thi_ff       <= '0;
         dist_ff      <= '0;
         cpu_ff       <= '0;
         pmask_ff     <= '0;
         bp_ff        <= '0;
         clr_ff       <= '0;
         siss_ff      <= 1'b0;
         svld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         en_ff   <= en_in;
         pend_ff <= pend_in;
         act_ff  <= act_in;
         line_ff <= line_in;
         tlo_ff  <= tlo_in;
         thi_ff  <= thi_in;
         if (cmd.clr_en) clr_ff <= AW'(clr_ff + 1'b1);
         if (cmd.issue && is_write) begin
            if (a == ADDR_DIST_CTRL) dist_ff  <= d[1:0];
            if (a == ADDR_CPU_CTRL)  cpu_ff   <= d[3:0];
            if (a == ADDR_PMASK)     pmask_ff <= d[7:0];
            if (a == ADDR_BPOINT)    bp_ff    <= d[2:0];
         end
         if (cmd.scan_init) begin
            siss_ff <= 1'b1;
         end else if (issuing && (scnt_ff == IW'(NUM_IRQS - 1))) begin
            siss_ff <= 1'b0;
         end
         svld_ff      <= issuing;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) req_ff <= req_data;
      if (cmd.scan_init) begin
         scnt_ff     <= '0;
         best_pri_ff <= NO_PRIO;
         best_id_ff  <= SPURIOUS_ID;
         run_pri_ff  <= IDLE_PRIO;
      end else begin
         if (issuing) scnt_ff <= IW'(scnt_ff + 1'b1);
         if (svld_ff) begin
            if (s_qual && ({1'b0, s_pri} < best_pri_ff)) begin
               best_pri_ff <= {1'b0, s_pri};
               best_id_ff  <= 10'(sid_ff);
            end
            if (act_ff[PIW'(sid_ff)] && (s_pri < run_pri_ff)) run_pri_ff <= s_pri;
         end
      end
      sid_ff <= scnt_ff;
      if (cmd.ack_apply) ack_id_ff <= best_gated;
      if (cmd.capture) rd_ff <= is_read ? bus_rd : 32'd0;
      if (cmd.respond) begin
         if (!is_read)              rsp_ff.read_data <= 32'd0;
         else if (a == ADDR_ACK)       rsp_ff.read_data <= 32'(ack_id_ff);
         else if (a == ADDR_RUN_PRIO)  rsp_ff.read_data <= 32'(run_pri_ff);
         else if (a == ADDR_HIGH_PEND) rsp_ff.read_data <= 32'(best_gated);
         else                          rsp_ff.read_data <= rd_ff;
         rsp_ff.irq_request <= (best_gated != SPURIOUS_ID);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_pad_clear: assert property (@(posedge clock) disable iff (reset)
      ((en_ff | pend_ff | act_ff) & ~VALID) == '0)
      else $error("state set beyond last interrupt");
   a_ack_active: assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.ack_apply) && (ack_id_ff != SPURIOUS_ID)) |-> act_ff[PIW'(ack_id_ff)])
      else $error("acknowledged interrupt not active");
   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !siss_ff)
      else $error("response while scan still running");
`endif

endmodule

[test/idc_checker.sv]
`timescale 1ns / 1ps

module idc_checker
   import idc_pkg::*;
#(
   parameter int NUM_IRQS = DEFAULT_NUM_IRQS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      errors,
   output int      outstanding
);

   logic       en_bit   [NUM_IRQS];
   logic       pend_bit [NUM_IRQS];
   logic       act_bit  [NUM_IRQS];
   logic [7:0] prio     [NUM_IRQS];
   logic [7:0] tgt      [NUM_IRQS];
   logic [1:0] trig     [NUM_IRQS];
   logic       line     [NUM_IRQS];
   logic [1:0] dist_ctrl;
   logic [3:0] cpu_ctrl;
   logic [7:0] pmask;
   logic [2:0] bpoint;

   rsp_type expected_rsp[$];

   assign outstanding = expected_rsp.size();

   function automatic logic [31:0] best_irq();
      logic [31:0] best;
      logic [8:0]  best_prio;
      best = SPURIOUS_ID;
      best_prio = NO_PRIO;
      if (!dist_ctrl[0] || !cpu_ctrl[0])
         return best;
      for (int n = 0; n < NUM_IRQS; n++) begin
         if (!en_bit[n] || !pend_bit[n] || act_bit[n]) continue;
         if (prio[n] >= pmask) continue;
         if (n >= 32 && !tgt[n][0]) continue;
         if ({1'b0, prio[n]} < best_prio) begin
            best_prio = {1'b0, prio[n]};
            best = n;
         end
      end
      return best;
   endfunction

   function automatic logic [31:0] bus_read(logic [15:0] a);
      logic [31:0] v;
      logic [31:0] b;
      int          grp;
      v = '0;
      if (a == ADDR_DIST_CTRL) return dist_ctrl;
      if (a == ADDR_TYPE) return ((NUM_IRQS + 31) / 32 - 1) & 32'h1f;
      if (a >= ADDR_BITS_LO && a < ADDR_PRIO_LO) begin
         grp = (a - ADDR_BITS_LO) >> 5;
         for (int k = 0; k < 32; k++) begin
            int n;
            n = (a & 16'h1f) * 32 + k;
            if (n < NUM_IRQS) begin
               if (grp == GRP_SET_EN || grp == GRP_CLR_EN) v[k] = en_bit[n];
               else if (grp == GRP_SET_PEND || grp == GRP_CLR_PEND) v[k] = pend_bit[n];
               else v[k] = act_bit[n];
            end
         end
         return v;
      end
      if (a >= ADDR_PRIO_LO && a < ADDR_TRIG_LO) begin
         for (int k = 0; k < 4; k++) begin
            int n;
            n = (a & 16'hff) * 4 + k;
            if (n < NUM_IRQS) v[8*k +: 8] = (a < ADDR_TGT_LO) ? prio[n] : tgt[n];
         end
         return v;
      end
      if (a >= ADDR_TRIG_LO && a < ADDR_TRIG_HI) begin
         for (int k = 0; k < 16; k++) begin
            int n;
            n = (a - ADDR_TRIG_LO) * 16 + k;
            if (n < NUM_IRQS) v[2*k +: 2] = trig[n];
         end
         return v;
      end
      if (a == ADDR_CPU_CTRL) return cpu_ctrl;
      if (a == ADDR_PMASK) return pmask;
      if (a == ADDR_BPOINT) return bpoint;
      if (a == ADDR_ACK) begin
         b = best_irq();
         if (b < NUM_IRQS) begin
            act_bit[b] = 1'b1;
            if (trig[b][1] || !line[b]) pend_bit[b] = 1'b0;
         end
         return b;
      end
      if (a == ADDR_RUN_PRIO) begin
         v = IDLE_PRIO;
         for (int n = 0; n < NUM_IRQS; n++)
            if (act_bit[n] && prio[n] < v) v = prio[n];
         return v;
      end
      if (a == ADDR_HIGH_PEND) return best_irq();
      return '0;
   endfunction

   function automatic void bus_write(logic [15:0] a, logic [31:0] d);
      int grp;
      if (a == ADDR_DIST_CTRL) dist_ctrl = d[1:0];
      else if (a >= ADDR_BITS_LO && a < ADDR_PRIO_LO) begin
         grp = (a - ADDR_BITS_LO) >> 5;
         for (int k = 0; k < 32; k++) begin
            int n;
            n = (a & 16'h1f) * 32 + k;
            if (n >= NUM_IRQS || !d[k]) continue;
            case (grp)
               GRP_SET_EN:   en_bit[n] = 1'b1;
               GRP_CLR_EN:   en_bit[n] = 1'b0;
               GRP_SET_PEND: pend_bit[n] = 1'b1;
               GRP_CLR_PEND: pend_bit[n] = !trig[n][1] && line[n];
               GRP_SET_ACT:  act_bit[n] = 1'b1;
               default:      act_bit[n] = 1'b0;
            endcase
         end
      end else if (a >= ADDR_PRIO_LO && a < ADDR_TRIG_LO) begin
         for (int k = 0; k < 4; k++) begin
            int n;
            n = (a & 16'hff) * 4 + k;
            if (n < NUM_IRQS) begin
               if (a < ADDR_TGT_LO) prio[n] = d[8*k +: 8];
               else tgt[n] = d[8*k +: 8];
            end
         end
      end else if (a >= ADDR_TRIG_LO && a < ADDR_TRIG_HI) begin
         for (int k = 0; k < 16; k++) begin
            int n;
            n = (a - ADDR_TRIG_LO) * 16 + k;
            if (n < NUM_IRQS) trig[n] = d[2*k +: 2];
         end
      end else if (a == ADDR_CPU_CTRL) cpu_ctrl = d[3:0];
      else if (a == ADDR_PMASK) pmask = d[7:0];
      else if (a == ADDR_BPOINT) bpoint = d[2:0];
      else if (a == ADDR_EOI) begin
         if ((d & SPURIOUS_ID) < NUM_IRQS) act_bit[d & SPURIOUS_ID] = 1'b0;
      end
   endfunction

   function automatic rsp_type controller_step(req_type r);
      rsp_type e;
      e = '0;
      if (r.action == ACT_READ)
         e.read_data = bus_read(r.word_addr);
      else if (r.action == ACT_WRITE)
         bus_write(r.word_addr, r.write_data);
      else if (r.action == ACT_LINE && r.source_id < NUM_IRQS) begin
         // edge mode latches a rising edge only; level mode tracks the line
         if (trig[r.source_id][1]) begin
            if (r.source_level && !line[r.source_id]) pend_bit[r.source_id] = 1'b1;
         end else
            pend_bit[r.source_id] = r.source_level;
         line[r.source_id] = r.source_level;
      end
      e.irq_request = best_irq() < NUM_IRQS;
      return e;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NUM_IRQS; n++) begin
            en_bit[n] = 0; pend_bit[n] = 0; act_bit[n] = 0;
            prio[n] = 0; tgt[n] = 0; trig[n] = 0; line[n] = 0;
         end
         dist_ctrl = 0; cpu_ctrl = 0; pmask = 0; bpoint = 0;
         expected_rsp.delete();
         errors = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t unexpected response: expected none actual %h", $time, rsp_data);
               errors++;
            end else begin
               rsp_type e;
               e = expected_rsp.pop_front();
               if (rsp_data.read_data !== e.read_data) begin
                  $display("%0t read_data expected %h actual %h",
                           $time, e.read_data, rsp_data.read_data);
                  errors++;
               end
               if (rsp_data.irq_request !== e.irq_request) begin
                  $display("%0t irq_request expected %b actual %b",
                           $time, e.irq_request, rsp_data.irq_request);
                  errors++;
               end
            end
         end
         if (start && !busy)
            expected_rsp.push_back(controller_step(req_data));
      end
   end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
   import idc_pkg::*;

   localparam int NUM_IRQS = DEFAULT_NUM_IRQS;
   localparam int N_RANDOM = 1530;
   localparam longint CYCLE_LIMIT = 3000000;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      errors;
   int      outstanding;
   longint  cycles = 0;
   int      burst_left = 0;

   always #5 clock = ~clock;

   interrupt_distributor_cpu_interface #(.NUM_IRQS(NUM_IRQS)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   idc_checker #(.NUM_IRQS(NUM_IRQS)) i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .errors(errors), .outstanding(outstanding)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("interrupt_distributor_cpu_interface verification failed");
         $finish;
      end
   end

   function automatic req_type mk(logic [1:0] act, logic [15:0] a, logic [31:0] d,
                                  logic [7:0] id = 0, logic lvl = 0);
      req_type r;
      r.action = act; r.word_addr = a; r.write_data = d;
      r.source_id = id; r.source_level = lvl;
      return r;
   endfunction

   task automatic send(input req_type r);
      // close the burst and hold off for a random gap
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [15:0] bits_addr(logic [2:0] grp);
      int w;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
      return ADDR_BITS_LO + grp * 32 + w;
   endfunction

   function automatic req_type random_request();
      logic [31:0] d;
      int          sel;
      d = $urandom;
      sel = $urandom_range(0, 99);
      if (sel < 28)
         return mk(ACT_LINE, $urandom, d, $urandom_range(0, NUM_IRQS - 1), $urandom);
      if (sel < 42) return mk(ACT_READ, ADDR_ACK, d);
      if (sel < 52) return mk(ACT_WRITE, ADDR_EOI, {d[31:10], 10'($urandom_range(0, 200))});
      if (sel < 58) return mk(ACT_WRITE, bits_addr(GRP_SET_EN), d);
      if (sel < 61) return mk(ACT_WRITE, bits_addr(GRP_CLR_EN), d & $urandom);
      if (sel < 64) return mk(ACT_WRITE, bits_addr(3'($urandom_range(GRP_SET_PEND, GRP_CLR_ACT))),
                              d & $urandom);
      if (sel < 69) return mk(ACT_WRITE, ADDR_PRIO_LO + (($urandom_range(0, 7) == 0) ?
                              $urandom_range(0, 255) : $urandom_range(0, 47)), d);
      if (sel < 73) return mk(ACT_WRITE, ADDR_TGT_LO + (($urandom_range(0, 7) == 0) ?
                              $urandom_range(0, 255) : $urandom_range(0, 47)),
                              ($urandom_range(0, 3) == 0) ? d : d | 32'h01010101);
      if (sel < 76) return mk(ACT_WRITE, ADDR_TRIG_LO + $urandom_range(0, 15), d);
      if (sel < 79) begin
         // keep the controller mostly switched on so that arbitration is reached
         sel = $urandom_range(0, 3);
         if (sel == 0) return mk(ACT_WRITE, ADDR_DIST_CTRL, ($urandom_range(0, 4) == 0) ? d : d | 1);
         if (sel == 1) return mk(ACT_WRITE, ADDR_CPU_CTRL, ($urandom_range(0, 4) == 0) ? d : d | 1);
         if (sel == 2) return mk(ACT_WRITE, ADDR_PMASK, ($urandom_range(0, 4) == 0) ? d : d | 32'hc0);
         return mk(ACT_WRITE, ADDR_BPOINT, d);
      end
      if (sel < 93) begin
         sel = $urandom_range(0, 7);
         case (sel)
            0: return mk(ACT_READ, bits_addr(3'($urandom_range(GRP_SET_EN, GRP_CLR_ACT))), d);
            1: return mk(ACT_READ, ADDR_PRIO_LO + $urandom_range(0, 511), d);
            2: return mk(ACT_READ, ADDR_TRIG_LO + $urandom_range(0, 63), d);
            3: return mk(ACT_READ, ADDR_RUN_PRIO, d);
            4: return mk(ACT_READ, ADDR_HIGH_PEND, d);
            5: return mk(ACT_READ, ADDR_DIST_CTRL + $urandom_range(0, 1), d);
            default: return mk(ACT_READ, ADDR_CPU_CTRL + $urandom_range(0, 6), d);
         endcase
      end
      // noise anywhere in the map
      return mk(2'($urandom_range(ACT_READ, ACT_WRITE)), $urandom_range(0, 32768), d,
                $urandom_range(0, NUM_IRQS - 1), $urandom);
   endfunction

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send(mk(ACT_READ, ADDR_TYPE, 0));
      send(mk(ACT_READ, ADDR_ACK, 0));
      send(mk(ACT_READ, ADDR_RUN_PRIO, 0));
      send(mk(ACT_WRITE, ADDR_DIST_CTRL, 32'hffffffff));
      send(mk(ACT_WRITE, ADDR_CPU_CTRL, 32'hffffffff));
      send(mk(ACT_WRITE, ADDR_PMASK, 32'hffffffff));
      send(mk(ACT_WRITE, ADDR_BPOINT, 32'hffffffff));
      send(mk(ACT_WRITE, ADDR_PRIO_LO, 32'h10ff2010));
      send(mk(ACT_WRITE, ADDR_TGT_LO + 47, 32'hffffffff));
      send(mk(ACT_WRITE, ADDR_BITS_LO + GRP_SET_EN * 32, 32'hffffffff));
      send(mk(ACT_WRITE, ADDR_BITS_LO + GRP_SET_EN * 32 + 5, 32'hffffffff));
      send(mk(ACT_WRITE, ADDR_TRIG_LO, 32'h000000a0));
      send(mk(ACT_LINE, 0, 0, 8'd2, 1'b1));
      send(mk(ACT_LINE, 0, 0, 8'd0, 1'b1));
      send(mk(ACT_LINE, 0, 0, 8'd191, 1'b1));
      send(mk(ACT_READ, ADDR_HIGH_PEND, 0));
      send(mk(ACT_READ, ADDR_ACK, 0));
      send(mk(ACT_READ, ADDR_ACK, 0));
      send(mk(ACT_READ, ADDR_RUN_PRIO, 0));
      send(mk(ACT_LINE, 0, 0, 8'd2, 1'b0));
      send(mk(ACT_WRITE, ADDR_BITS_LO + GRP_CLR_PEND * 32, 32'hffffffff));
      send(mk(ACT_WRITE, ADDR_EOI, 32'hffffffff));
      send(mk(ACT_WRITE, ADDR_EOI, 32'd0));
      send(mk(ACT_WRITE, 16'h8000, 32'hffffffff));
      send(mk(ACT_READ, 16'h7fff, 0));

      for (int i = 0; i < N_RANDOM; i++)
         send(random_request());
      start <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (2 * NUM_IRQS + 40) @(posedge clock);
      if (errors == 0)
         $display("interrupt_distributor_cpu_interface verification clean");
      else
         $display("interrupt_distributor_cpu_interface verification failed");
      $finish;
   end

endmodule

[filelist.f]
sv/idc_pkg.sv
sv/idc_ram.sv
sv/idc_ctrl.sv
sv/idc_datapath.sv
sv/interrupt_distributor_cpu_interface.sv
test/idc_checker.sv
test/tb.sv
